// ===== hdl/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character codes and reference-name tables for the HTML
// entity decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hed_pkg;

  // held named prefix depth and bytes one request can produce
  localparam int PEND_DEPTH  = 5;
  localparam int JOB_BYTES   = 6;
  localparam int NAME_NUM    = 4;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  // character codes
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // bytes to emit for one request, oldest in data[0]
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] data;
    logic [2:0]                count;
    logic                      text_end;
  } job_t;

  // text of the named references: &amp; &quot; &lt; &gt;
  function automatic logic [7:0] name_byte(input logic [1:0] k, input logic [2:0] j);
    logic [7:0] b;
    b = 8'h00;
    case ({k, j})
      {2'd0, 3'd0}: b = CH_AMP;
      {2'd0, 3'd1}: b = 8'h61;
      {2'd0, 3'd2}: b = 8'h6D;
      {2'd0, 3'd3}: b = 8'h70;
      {2'd0, 3'd4}: b = CH_SEMI;
      {2'd1, 3'd0}: b = CH_AMP;
      {2'd1, 3'd1}: b = 8'h71;
      {2'd1, 3'd2}: b = 8'h75;
      {2'd1, 3'd3}: b = 8'h6F;
      {2'd1, 3'd4}: b = 8'h74;
      {2'd1, 3'd5}: b = CH_SEMI;
      {2'd2, 3'd0}: b = CH_AMP;
      {2'd2, 3'd1}: b = 8'h6C;
      {2'd2, 3'd2}: b = 8'h74;
      {2'd2, 3'd3}: b = CH_SEMI;
      {2'd3, 3'd0}: b = CH_AMP;
      {2'd3, 3'd1}: b = 8'h67;
      {2'd3, 3'd2}: b = 8'h74;
      {2'd3, 3'd3}: b = CH_SEMI;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] name_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd5;
      2'd1:    n = 3'd6;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = CH_AMP;
      2'd1:    b = 8'h22;
      2'd2:    b = 8'h3C;
      default: b = 8'h3E;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hed_front.sv =====
// ----------------------------------------------------------------------------
// hed_front
// Scans each input byte against the named and numeric reference rules and
// turns it into a job: the list of bytes to emit and the end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_front #(
  parameter int MAX_DIGITS = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          end_of_text,
  output hed_pkg::job_t      job,
  output logic               job_push
);

  localparam int DCW = $clog2(MAX_DIGITS + 1);

  // decoder modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_NAMED  = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  // numeric field scan phases
  localparam logic [1:0] PH_WS   = 2'd0;
  localparam logic [1:0] PH_SIGN = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;
  localparam logic [1:0] PH_BAD  = 2'd3;

  logic [1:0]     mode, mode_next;
  logic [7:0]     pend [hed_pkg::PEND_DEPTH];
  logic [7:0]     pend_next [hed_pkg::PEND_DEPTH];
  logic [2:0]     cnt, cnt_next;
  logic [DCW-1:0] dig, dig_next;
  logic [1:0]     phase, phase_next;
  logic           neg, neg_next;
  logic [7:0]     val, val_next;

  logic [1:0]     eff_mode;
  logic [2:0]     eff_cnt, eff_len;
  logic [7:0]     cand [hed_pkg::JOB_BYTES];
  logic [hed_pkg::NAME_NUM-1:0] pm;
  logic           any_full;
  logic [7:0]     full_char;
  logic           is_digit, is_ws;
  logic           fld_ok;
  logic [7:0]     fld_byte;
  logic [7:0]     jb [hed_pkg::JOB_BYTES];
  logic [2:0]     jc;

  // sanitize mode, bad states fall back to plain text
  always_comb begin
    eff_mode = MODE_PLAIN;
    if (mode == MODE_NAMED && cnt != 3'd0 && cnt <= 3'(hed_pkg::PEND_DEPTH)) begin
      eff_mode = MODE_NAMED;
    end else if (mode == MODE_DIGITS) begin
      eff_mode = MODE_DIGITS;
    end
    eff_cnt = (eff_mode == MODE_NAMED) ? cnt : 3'd0;
    eff_len = eff_cnt + 3'd1;
  end

  // candidate string: held prefix followed by the new byte
  always_comb begin
    for (int j = 0; j < hed_pkg::PEND_DEPTH; j++) begin
      cand[j] = (3'(j) < eff_cnt) ? pend[j] : in_byte;
    end
    cand[hed_pkg::PEND_DEPTH] = in_byte;
  end

  // prefix and full match against each named reference
  always_comb begin
    any_full  = 1'b0;
    full_char = 8'h00;
    for (int k = 0; k < hed_pkg::NAME_NUM; k++) begin
      pm[k] = (eff_len <= hed_pkg::name_len(2'(k)));
      for (int j = 0; j < hed_pkg::JOB_BYTES; j++) begin
        if (3'(j) < eff_len && cand[j] != hed_pkg::name_byte(2'(k), 3'(j))) begin
          pm[k] = 1'b0;
        end
      end
      if (pm[k] && eff_len == hed_pkg::name_len(2'(k))) begin
        any_full  = 1'b1;
        full_char = hed_pkg::name_char(2'(k));
      end
    end
  end

  // character classes
  assign is_digit = (in_byte >= hed_pkg::CH_ZERO) && (in_byte <= hed_pkg::CH_NINE);
  assign is_ws    = (in_byte == hed_pkg::CH_SPACE) ||
                    ((in_byte >= hed_pkg::CH_TAB) && (in_byte <= hed_pkg::CH_CR));

  // field result from the collected state
  assign fld_ok   = (phase == PH_DIG);
  assign fld_byte = neg ? (8'd0 - val) : val;

  // next state and job contents
  always_comb begin
    mode_next  = mode;
    pend_next  = pend;
    cnt_next   = cnt;
    dig_next   = dig;
    phase_next = phase;
    neg_next   = neg;
    val_next   = val;
    jb         = cand;
    jc         = 3'd0;

    case (eff_mode)
      MODE_NAMED: begin
        if (any_full) begin
          jb[0]     = full_char;
          jc        = 3'd1;
          mode_next = MODE_PLAIN;
          cnt_next  = 3'd0;
          dig_next  = '0;
        end else if ((|pm) && eff_cnt < 3'(hed_pkg::PEND_DEPTH)) begin
          for (int j = 0; j < hed_pkg::PEND_DEPTH; j++) begin
            if (3'(j) == eff_cnt) begin
              pend_next[j] = in_byte;
            end
          end
          cnt_next = eff_len;
        end else if (eff_cnt == 3'd1 && in_byte == hed_pkg::CH_HASH) begin
          mode_next  = MODE_DIGITS;
          cnt_next   = 3'd0;
          dig_next   = '0;
          phase_next = PH_WS;
          neg_next   = 1'b0;
          val_next   = 8'd0;
        end else begin
          // mismatch: release held bytes, then rescan the new one
          dig_next = '0;
          if (in_byte == hed_pkg::CH_AMP) begin
            pend_next[0] = hed_pkg::CH_AMP;
            cnt_next     = 3'd1;
            mode_next    = MODE_NAMED;
            jc           = eff_cnt;
          end else begin
            cnt_next  = 3'd0;
            mode_next = MODE_PLAIN;
            jc        = eff_len;
          end
        end
      end
      MODE_DIGITS: begin
        if (in_byte == hed_pkg::CH_SEMI || dig >= DCW'(MAX_DIGITS)) begin
          if (fld_ok) begin
            jb[0] = fld_byte;
            jc    = 3'd1;
          end
          mode_next = MODE_PLAIN;
          cnt_next  = 3'd0;
          dig_next  = '0;
        end else begin
          dig_next = dig + DCW'(1);
          if (is_digit) begin
            val_next = {val[4:0], 3'b000} + {val[6:0], 1'b0} + {4'd0, in_byte[3:0]};
          end
          case (phase)
            PH_WS: begin
              if (is_ws) begin
                phase_next = PH_WS;
              end else if (in_byte == hed_pkg::CH_PLUS) begin
                phase_next = PH_SIGN;
              end else if (in_byte == hed_pkg::CH_MINUS) begin
                phase_next = PH_SIGN;
                neg_next   = 1'b1;
              end else if (is_digit) begin
                phase_next = PH_DIG;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_SIGN, PH_DIG: begin
              phase_next = is_digit ? PH_DIG : PH_BAD;
            end
            default: begin
              phase_next = PH_BAD;
            end
          endcase
        end
      end
      default: begin
        cnt_next = 3'd0;
        dig_next = '0;
        if (in_byte == hed_pkg::CH_AMP) begin
          pend_next[0] = hed_pkg::CH_AMP;
          cnt_next     = 3'd1;
          mode_next    = MODE_NAMED;
        end else begin
          jc        = 3'd1;
          mode_next = MODE_PLAIN;
        end
      end
    endcase

    // end of text flushes a held prefix or closes an open numeric field
    if (end_of_text) begin
      if (mode_next == MODE_NAMED) begin
        jb = cand;
        jc = eff_len;
      end else if (mode_next == MODE_DIGITS) begin
        if (phase_next == PH_DIG) begin
          jb[0] = neg_next ? (8'd0 - val_next) : val_next;
          jc    = 3'd1;
        end
      end
      mode_next = MODE_PLAIN;
      cnt_next  = 3'd0;
      dig_next  = '0;
    end
  end

  // job out to the queue
  always_comb begin
    for (int j = 0; j < hed_pkg::JOB_BYTES; j++) begin
      job.data[j] = jb[j];
    end
    job.count    = jc;
    job.text_end = end_of_text;
    job_push     = accept && (jc != 3'd0 || end_of_text);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      cnt   <= 3'd0;
      dig   <= '0;
      phase <= PH_WS;
      neg   <= 1'b0;
      val   <= 8'd0;
    end else if (accept) begin
      mode  <= mode_next;
      cnt   <= cnt_next;
      dig   <= dig_next;
      phase <= phase_next;
      neg   <= neg_next;
      val   <= val_next;
    end
  end

  // held prefix bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hed_queue.sv =====
// ----------------------------------------------------------------------------
// hed_queue
// Short job queue that decouples the scanning front from the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire hed_pkg::job_t push_job,
  input  wire logic          deq,
  output hed_pkg::job_t      head,
  output logic               head_valid,
  output logic               full
);

  hed_pkg::job_t            store [hed_pkg::QUEUE_DEPTH];
  logic [hed_pkg::QPW-1:0]  wr_ptr;
  logic [hed_pkg::QPW-1:0]  rd_ptr;
  logic [hed_pkg::QPW:0]    count;
  logic                     do_push;
  logic                     do_deq;

  assign full       = (count == (hed_pkg::QPW + 1)'(hed_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_deq     = deq && head_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + hed_pkg::QPW'(1);
      end
      if (do_deq) begin
        rd_ptr <= rd_ptr + hed_pkg::QPW'(1);
      end
      if (do_push && !do_deq) begin
        count <= count + (hed_pkg::QPW + 1)'(1);
      end else if (do_deq && !do_push) begin
        count <= count - (hed_pkg::QPW + 1)'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hed_back.sv =====
// ----------------------------------------------------------------------------
// hed_back
// Walks the head job one byte per cycle, when not held by a waiting result,
// into the result register; marks each request's and the text's last result.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hed_pkg::job_t head,
  input  wire logic          head_valid,
  output logic               deq,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               text_done
);

  logic       out_full;
  logic [2:0] idx;
  logic       load;
  logic       last;

  assign load  = head_valid && (!out_full || pop);
  assign last  = (head.count == 3'd0) || (idx == head.count - 3'd1);
  assign deq   = load && last;
  assign empty = !out_full;

  // result valid and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      idx      <= 3'd0;
    end else begin
      if (load) begin
        out_full <= 1'b1;
        idx      <= last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (head.count == 3'd0) begin
        out_byte   <= 8'd0;
        byte_valid <= 1'b0;
        run_last   <= 1'b1;
        text_done  <= 1'b1;
      end else begin
        out_byte   <= head.data[idx];
        byte_valid <= 1'b1;
        run_last   <= last;
        text_done  <= last && head.text_end;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/html_entity_decoder_unit.sv =====
// With the result side idle, a taken request is written into the job queue and
// then loaded into the result register, which drives its first result.
// Throughput: one input byte per cycle while full is low; results leave the
// back one per cycle while popped; each request holds it to its last result.
// A four-entry job queue absorbs bursts before full is raised.
// Reset: synchronous, clears decode state, job queue and result register.
// ----------------------------------------------------------------------------
// html_entity_decoder_unit
// Streaming decoder for &amp; &quot; &lt; &gt; and numeric references.
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_decoder_unit #(
  parameter int MAX_DIGITS = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_text,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            text_done,
  output logic            empty,
  input  wire logic       pop
);

  hed_pkg::job_t front_job;
  hed_pkg::job_t head;
  logic          accept;
  logic          job_push;
  logic          head_valid;
  logic          deq;

  assign accept = push && !full;

  // scan and classify
  hed_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .job         (front_job),
    .job_push    (job_push)
  );

  // decoupling queue
  hed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (front_job),
    .deq        (deq),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  // emit results
  hed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .deq        (deq),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_done  (text_done)
  );

endmodule

`default_nettype wire

// ===== hdl/hed_checker.sv =====
// ----------------------------------------------------------------------------
// hed_checker
// Port-level checks on the result side of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       run_last,
  input wire logic       text_done
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(byte_valid))
    else $error("result changed while waiting");

  // an empty result only closes a text
  a_blank: assert property (@(posedge clk) disable iff (rst)
    !empty && !byte_valid |-> run_last && text_done && out_byte == 8'd0)
    else $error("blank result not at end of text");

  // end of text is always the last result of its request
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    !empty && text_done |-> run_last)
    else $error("text_done without run_last");

  // nothing waiting right after reset
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("result present after reset");

endmodule

bind html_entity_decoder_unit hed_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .run_last   (run_last),
  .text_done  (text_done)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTML entity decoder. A short table of hand-picked
// requests with known results comes first, then random text built mostly from
// named and numeric references. A built-in decoder model predicts the results
// of untyped requests, and both handshake sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int MAX_DIGITS = 5;
  localparam int RAND_ITEMS = 300;

  // decoder state kept by the bench model
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_NAME = 2'd1,
    MODE_NUM  = 2'd2
  } dec_mode_t;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
    logic       done;
  } dec_out_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [7:0] w_ch;
    logic       w_valid;
    logic       w_last;
    logic       w_done;
  } step_t;

  logic       clk;
  logic       rst;
  logic [7:0] in_byte;
  logic       end_of_text;
  logic       push;
  logic       full;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;
  logic       empty;
  logic       pop;

  // sideband of the request on the ports
  logic     row_typed;
  dec_out_t row_want;

  // model state
  dec_mode_t  dec_mode;
  logic [7:0] held [hed_pkg::PEND_DEPTH];
  int         held_n;
  logic [7:0] field [MAX_DIGITS];
  int         field_n;
  logic [7:0] emitted [$];

  dec_out_t   decoded_q [$];
  dec_out_t   step_out [$];
  logic [7:0] frag [$];
  int         failures;
  int         in_count;
  logic       calm_in;
  logic       calm_out;

  string      ref_name [4] = '{"&amp;", "&quot;", "&lt;", "&gt;"};
  logic [7:0] ref_char [4] = '{hed_pkg::CH_AMP, 8'h22, 8'h3C, 8'h3E};
  logic [7:0] noise_char [7] = '{hed_pkg::CH_AMP, hed_pkg::CH_HASH, hed_pkg::CH_SEMI,
                                 "a", "q", "l", "g"};

  // directed table: &amp; &quot; &lt; and numeric references, extremes, end of text cases
  step_t plan [0:27] = '{
    '{"A",   1'b0, 1'b1, "A",   1'b1, 1'b1, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"a",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"m",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"p",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";",   1'b0, 1'b1, "&",   1'b1, 1'b1, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"q",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"u",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"o",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"t",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";",   1'b0, 1'b1, 8'h22, 1'b1, 1'b1, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"l",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"t",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";",   1'b0, 1'b1, "<",   1'b1, 1'b1, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"#",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{" ",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"-",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"0",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"0",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"1",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"Z",   1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0},
    '{"&",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"#",   1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1}
  };

  html_entity_decoder_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .push       (push),
    .full       (full),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_done  (text_done),
    .empty      (empty),
    .pop        (pop)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- model

  function automatic logic is_space(input logic [7:0] c);
    return c == hed_pkg::CH_SPACE || (c >= hed_pkg::CH_TAB && c <= hed_pkg::CH_CR);
  endfunction

  function automatic void go_text();
    dec_mode = MODE_TEXT;
    held_n   = 0;
    field_n  = 0;
  endfunction

  // optional blanks, optional sign, then digits to the end of the field
  function automatic void eval_field();
    int         i;
    logic       neg;
    logic [7:0] v;
    i   = 0;
    neg = 1'b0;
    v   = 8'h00;
    while (i < field_n && is_space(field[i])) i++;
    if (i < field_n && (field[i] == hed_pkg::CH_PLUS || field[i] == hed_pkg::CH_MINUS)) begin
      neg = (field[i] == hed_pkg::CH_MINUS);
      i++;
    end
    if (i >= field_n) return;
    while (i < field_n) begin
      if (field[i] < hed_pkg::CH_ZERO || field[i] > hed_pkg::CH_NINE) return;
      v = v * 8'd10 + (field[i] - hed_pkg::CH_ZERO);
      i++;
    end
    if (neg) v = 8'h00 - v;
    emitted.push_back(v);
  endfunction

  function automatic void take_text(input logic [7:0] c);
    if (c == hed_pkg::CH_AMP) begin
      held[0]  = c;
      held_n   = 1;
      dec_mode = MODE_NAME;
    end else begin
      emitted.push_back(c);
    end
  endfunction

  function automatic void take_name(input logic [7:0] c);
    logic [7:0] cand [hed_pkg::PEND_DEPTH+1];
    int         len;
    logic       prefix;
    logic       same;
    int         k;
    int         j;
    for (j = 0; j < held_n; j++) cand[j] = held[j];
    cand[held_n] = c;
    len    = held_n + 1;
    prefix = 1'b0;
    for (k = 0; k < 4; k++) begin
      if (len > ref_name[k].len()) continue;
      same = 1'b1;
      for (j = 0; j < len; j++)
        if (cand[j] != ref_name[k][j]) same = 1'b0;
      if (!same) continue;
      if (len == ref_name[k].len()) begin
        emitted.push_back(ref_char[k]);
        go_text();
        return;
      end
      prefix = 1'b1;
    end
    if (prefix && held_n < hed_pkg::PEND_DEPTH) begin
      held[held_n] = c;
      held_n++;
      return;
    end
    if (len == 2 && c == hed_pkg::CH_HASH) begin
      dec_mode = MODE_NUM;
      held_n   = 0;
      field_n  = 0;
      return;
    end
    // no reference: give back the held bytes and rescan the new one
    go_text();
    for (j = 0; j + 1 < len; j++) emitted.push_back(cand[j]);
    take_text(c);
  endfunction

  function automatic void take_num(input logic [7:0] c);
    if (c == hed_pkg::CH_SEMI || field_n >= MAX_DIGITS) begin
      eval_field();
      go_text();
    end else begin
      field[field_n] = c;
      field_n++;
    end
  endfunction

  // results of one request into step_out
  function automatic void decode_step(input logic [7:0] c, input logic eot);
    dec_out_t r;
    int       i;
    emitted.delete();
    step_out.delete();
    if (dec_mode == MODE_NAME && held_n >= 1 && held_n <= hed_pkg::PEND_DEPTH) take_name(c);
    else if (dec_mode == MODE_NUM) take_num(c);
    else begin
      go_text();
      take_text(c);
    end
    if (eot) begin
      if (dec_mode == MODE_NAME)
        for (i = 0; i < held_n; i++) emitted.push_back(held[i]);
      else if (dec_mode == MODE_NUM)
        eval_field();
      go_text();
    end
    if (emitted.size() == 0) begin
      if (eot) begin
        r = '{8'h00, 1'b0, 1'b1, 1'b1};
        step_out.push_back(r);
      end
    end else begin
      for (i = 0; i < emitted.size(); i++) begin
        r.ch    = emitted[i];
        r.valid = 1'b1;
        r.last  = (i == emitted.size() - 1);
        r.done  = r.last && eot;
        step_out.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return hed_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    if (r == 6) return $urandom_range(0, 1) ? hed_pkg::CH_SPACE : 8'($urandom_range(9, 13));
    if (r == 7) return hed_pkg::CH_PLUS;
    if (r == 8) return hed_pkg::CH_MINUS;
    return 8'($urandom_range(1, 255));
  endfunction

  // one piece of text: plain run, named reference, numeric reference or noise
  task automatic make_fragment();
    int kind;
    int n;
    int k;
    int j;
    int cut;
    frag.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      n = $urandom_range(1, 4);
      repeat (n) frag.push_back(8'($urandom_range(1, 255)));
    end else if (kind <= 5) begin
      k   = $urandom_range(0, 3);
      cut = ref_name[k].len();
      if ($urandom_range(0, 2) == 0) cut = $urandom_range(1, ref_name[k].len() - 1);
      for (j = 0; j < cut; j++) frag.push_back(ref_name[k][j]);
      if (cut < ref_name[k].len()) frag.push_back(8'($urandom_range(1, 255)));
    end else if (kind <= 8) begin
      frag.push_back(hed_pkg::CH_AMP);
      frag.push_back(hed_pkg::CH_HASH);
      n = $urandom_range(0, MAX_DIGITS);
      repeat (n) frag.push_back(field_char());
      if (n < MAX_DIGITS && $urandom_range(0, 3) != 0) frag.push_back(hed_pkg::CH_SEMI);
      else frag.push_back(8'($urandom_range(1, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) frag.push_back(noise_char[$urandom_range(0, 6)]);
    end
  endtask

  // present one request and hold it until taken
  task automatic send_byte(input logic [7:0] ch, input logic eot, input logic typed,
                           input dec_out_t want);
    int gap;
    if (in_count % 24 == 0) calm_in = ($urandom_range(0, 2) == 0);
    in_count++;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push        <= 1'b1;
    in_byte     <= ch;
    end_of_text <= eot;
    row_typed   <= typed;
    row_want    <= want;
    do @(posedge clk); while (full);
  endtask

  initial begin : stim
    int       sent;
    int       i;
    dec_out_t want;
    rst         = 1'b1;
    push        = 1'b0;
    in_byte     = 8'h00;
    end_of_text = 1'b0;
    row_typed   = 1'b0;
    row_want    = '0;
    failures    = 0;
    in_count    = 0;
    calm_in     = 1'b1;
    go_text();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < $size(plan); i++) begin
      want = '{plan[i].w_ch, plan[i].w_valid, plan[i].w_last, plan[i].w_done};
      send_byte(plan[i].ch, plan[i].eot, plan[i].typed, want);
    end

    // random text, mostly named and numeric references
    sent = 0;
    while (sent < RAND_ITEMS) begin
      make_fragment();
      foreach (frag[j]) begin
        send_byte(frag[j], $urandom_range(0, 14) == 0, 1'b0, '0);
        sent++;
      end
    end
    @(negedge clk);
    push <= 1'b0;

    // drain
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) failures++;
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // result side: random pop stalls with calm stretches
  initial begin : drain
    int gap;
    int n;
    pop      = 1'b0;
    n        = 0;
    calm_out = 1'b1;
    wait (!rst);
    forever begin
      if (n % 20 == 0) calm_out = ($urandom_range(0, 2) == 0);
      n++;
      gap = calm_out ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // ---------------------------------------------------------------- checking

  // predict on each accepted request, compare each accepted result
  always @(posedge clk) begin : score
    dec_out_t want;
    if (!rst) begin
      if (push && !full) begin
        decode_step(in_byte, end_of_text);
        if (row_typed) decoded_q.push_back(row_want);
        else foreach (step_out[i]) decoded_q.push_back(step_out[i]);
      end
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: byte %02h valid %0d last %0d done %0d",
                     out_byte, byte_valid, run_last, text_done);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.ch || byte_valid !== want.valid ||
              run_last !== want.last || text_done !== want.done) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: want %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                       want.ch, want.valid, want.last, want.done,
                       out_byte, byte_valid, run_last, text_done);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/hed_pkg.sv
hdl/hed_front.sv
hdl/hed_queue.sv
hdl/hed_back.sv
hdl/html_entity_decoder_unit.sv
hdl/hed_checker.sv
dv/tb.sv
